// File: src/assert_macros.svh
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: src/rgbhsv_pkg.sv
// Package for the RGB to HSV pixel converter.
// Types and constants shared by the front, queue, divider and top level.
package rgbhsv_pkg;
  localparam int QueueDepth = 2;
  localparam int NumW  = 20;   // hue numerator, 3840*diff, magnitude
  localparam int SNumW = 16;   // saturation numerator, delta*255
  localparam logic [14:0] Hue120 = 15'd7680;
  localparam logic [14:0] Hue240 = 15'd15360;
  localparam logic [14:0] Hue360 = 15'd23040;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [NumW-1:0]  hnum;    // |diff| * 3840
    logic             hneg;    // diff negative
    logic [14:0]      hbase;   // sector base
    logic [7:0]       delta;
    logic [SNumW-1:0] snum;    // delta * 255
    logic [7:0]       vmax;
    logic             last;
  } work_t;
endpackage

// File: src/rgbhsv_front.sv
// Front part: finds max, min, sector and numerators of one pixel.
// Depends on rgbhsv_pkg. Registered output with valid/ready.
module rgbhsv_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         r,
  input  logic [7:0]         g,
  input  logic [7:0]         b,
  input  logic               lst,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbhsv_pkg::work_t  out_data
);
  localparam logic [1:0] SecRed   = 2'd0;
  localparam logic [1:0] SecGreen = 2'd1;
  localparam logic [1:0] SecBlue  = 2'd2;

  logic [7:0] mx, mn, d;
  logic [1:0] sector;
  logic signed [8:0] diff;
  logic [8:0] mag;
  rgbhsv_pkg::work_t w;

  assign in_ready = !out_valid || out_ready;

  // classification
  always_comb begin
    if (r > g) begin
      mx = r; sector = SecRed;
    end else begin
      mx = g; sector = SecGreen;
    end
    if (b > mx) begin
      mx = b; sector = SecBlue;
    end
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d = mx - mn;
    case (sector)
      SecRed:   diff = $signed({1'b0, g}) - $signed({1'b0, b});
      SecGreen: diff = $signed({1'b0, b}) - $signed({1'b0, r});
      default:  diff = $signed({1'b0, r}) - $signed({1'b0, g});
    endcase
    mag = diff[8] ? 9'(-diff) : 9'(diff);
    w.hneg  = diff[8];
    w.hnum  = {{(rgbhsv_pkg::NumW-9){1'b0}}, mag} * rgbhsv_pkg::NumW'(3840);
    case (sector)
      SecRed:   w.hbase = diff[8] ? rgbhsv_pkg::Hue360 : 15'd0;
      SecGreen: w.hbase = rgbhsv_pkg::Hue120;
      default:  w.hbase = rgbhsv_pkg::Hue240;
    endcase
    w.delta = d;
    w.snum  = rgbhsv_pkg::SNumW'({8'd0, d} * 16'd255);
    w.vmax  = mx;
    w.last  = lst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) out_data <= w;
  end
endmodule

// File: src/rgbhsv_queue.sv
// Short FIFO between front and back parts.
// Depends on rgbhsv_pkg for the item type.
module rgbhsv_queue #(
  parameter int Depth = rgbhsv_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbhsv_pkg::work_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbhsv_pkg::work_t  out_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  rgbhsv_pkg::work_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign in_ready  = cnt != (AW+1)'(Depth);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= in_data;
  end
endmodule

// File: src/rgbhsv_back.sv
// Back part: pipelined restoring dividers for hue and saturation.
// Depends on rgbhsv_pkg. One quotient bit per stage, one pixel per cycle unless stalled.
module rgbhsv_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbhsv_pkg::work_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        hue,
  output logic [7:0]         sat,
  output logic [7:0]         val,
  output logic               lst
);
  localparam int NW = rgbhsv_pkg::NumW;
  localparam int SW = rgbhsv_pkg::SNumW;
  localparam int St = NW;  // stages; saturation uses the last SW

  typedef struct packed {
    logic          v;
    logic [NW-1:0] hrem_q; // hue: shifting numerator/quotient
    logic [8:0]    hr;     // hue partial remainder
    logic [SW-1:0] srem_q;
    logic [8:0]    sr;
    logic          hneg;
    logic [14:0]   hbase;
    logic [7:0]    delta;
    logic [7:0]    vmax;
    logic          last;
  } stg_t;

  stg_t s [St+1];
  stg_t nx [St];
  logic adv;
  logic [NW-1:0] hq;
  logic [14:0] hf;
  logic exact;

  assign adv = !s[St].v || out_ready;
  assign in_ready = adv;

  // stage input
  always_comb begin
    s[0].v      = in_valid;
    s[0].hrem_q = in_data.hnum;
    s[0].hr     = '0;
    s[0].srem_q = in_data.snum;
    s[0].sr     = '0;
    s[0].hneg   = in_data.hneg;
    s[0].hbase  = in_data.hbase;
    s[0].delta  = in_data.delta;
    s[0].vmax   = in_data.vmax;
    s[0].last   = in_data.last;
  end

  // one restoring step per stage
  for (genvar i = 0; i < St; i++) begin : g_st
    logic [8:0] ht, st;
    always_comb begin
      nx[i] = s[i];
      ht = {s[i].hr[7:0], s[i].hrem_q[NW-1]};
      if (ht >= {1'b0, s[i].delta}) begin
        nx[i].hr = ht - {1'b0, s[i].delta};
        nx[i].hrem_q = {s[i].hrem_q[NW-2:0], 1'b1};
      end else begin
        nx[i].hr = ht;
        nx[i].hrem_q = {s[i].hrem_q[NW-2:0], 1'b0};
      end
      st = {s[i].sr[7:0], s[i].srem_q[SW-1]};
      if (i >= NW - SW) begin
        if (st >= {1'b0, s[i].vmax}) begin
          nx[i].sr = st - {1'b0, s[i].vmax};
          nx[i].srem_q = {s[i].srem_q[SW-2:0], 1'b1};
        end else begin
          nx[i].sr = st;
          nx[i].srem_q = {s[i].srem_q[SW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) s[i+1].v <= 1'b0;
      else if (adv) s[i+1].v <= nx[i].v;
      if (adv) begin
        s[i+1].hrem_q <= nx[i].hrem_q; s[i+1].hr <= nx[i].hr;
        s[i+1].srem_q <= nx[i].srem_q; s[i+1].sr <= nx[i].sr;
        s[i+1].hneg <= nx[i].hneg;     s[i+1].hbase <= nx[i].hbase;
        s[i+1].delta <= nx[i].delta;   s[i+1].vmax <= nx[i].vmax;
        s[i+1].last <= nx[i].last;
      end
    end
  end

  // combine: negative offset floors as base - ceil(q)
  always_comb begin
    hq = s[St].hrem_q;
    exact = s[St].hr == '0;
    if (s[St].delta == '0) hf = '0;
    else if (s[St].hneg)
      hf = s[St].hbase - hq[14:0] - 15'(!exact);
    else hf = s[St].hbase + hq[14:0];
  end

  assign out_valid = s[St].v;
  assign hue = hf;
  assign sat = (s[St].vmax == '0) ? 8'd0 : s[St].srem_q[7:0];
  assign val = s[St].vmax;
  assign lst = s[St].last;
endmodule

// File: src/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_queue, rgbhsv_back.
//
// Use: pixels enter on the s_axis channel (tdata = red, green, blue from
// bit 0 up, tlast marks the last pixel of an image) and leave on m_axis
// (tdata = hue 15 bits, saturation, value; tlast copied through).
// Throughput is one pixel per clock unless the receiver stalls. Through
// an empty block a pixel passes the front register, the queue and the
// divider pipeline. The pipeline length is set by the hue divider, which
// resolves one quotient bit per stage over a 20-bit numerator.
// Hue is in 1/64 degree, truncated; saturation is delta*255/max.
// Synchronous reset empties all stages; no pixel is in flight afterward.
// When the receiver stalls, the back pipeline holds, the two-entry queue
// fills, then the front holds and s_axis_tready drops. No pixel is lost.
`include "assert_macros.svh"
module rgb_to_hsv_pixel #(
  parameter int QueueDepth = rgbhsv_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // hue[14:0], saturation[22:15], value[30:23], 0
  output logic        m_axis_tlast
);
  rgbhsv_pkg::work_t f_data, q_data;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [14:0] hue;
  logic [7:0] sat, val;

  rgbhsv_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .r(s_axis_tdata[7:0]), .g(s_axis_tdata[15:8]), .b(s_axis_tdata[23:16]),
    .lst(s_axis_tlast),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  rgbhsv_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  rgbhsv_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .hue(hue), .sat(sat), .val(val), .lst(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, val, sat, hue};

  // checks
  `ASSERT_IMPL(a_hue_range, clk, rst, !m_axis_tvalid || hue < 15'd23040, "hue out of range")
  `ASSERT_IMPL(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped while stalled")
  `ASSERT_IMPL(a_grey, clk, rst, m_axis_tvalid && sat == 8'd0 |-> hue == 15'd0, "grey pixel with nonzero hue")
endmodule

// File: tb/tb_rgb_to_hsv_pixel.sv
// Testbench for the RGB to HSV pixel converter.
// Depends on rgb_to_hsv_pixel; predicts hue, saturation and value per pixel.
module tb_rgb_to_hsv_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        last;
  } hsv_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red, green, blue from bit 0 up
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // hue, saturation, value, zero pad
  logic        m_axis_tlast;

  hsv_t expected_hsv[$];
  int   err_count;
  bit   send_idle_en;
  bit   recv_idle_en;
  int   hold_cycles;

  rgb_to_hsv_pixel dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hue in 1/64 degree, saturation, value for one pixel
  function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic lst);
    hsv_t o;
    int mx, mn, d, top;
    int sector;
    if (r > g) begin mx = r; sector = 0; end else begin mx = g; sector = 1; end
    if (b > mx) begin mx = b; sector = 2; end
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) top = 0;
    else if (sector == 0) top = (g < b ? 23040 * d : 0) + 3840 * (int'(g) - int'(b));
    else if (sector == 1) top = 7680 * d + 3840 * (int'(b) - int'(r));
    else top = 15360 * d + 3840 * (int'(r) - int'(g));
    o.hue  = (d == 0) ? 15'd0 : 15'(top / d);
    o.sat  = (mx == 0) ? 8'd0 : 8'((d * 255) / mx);
    o.val  = 8'(mx);
    o.last = lst;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // Offer one pixel, wait for the transaction; valid stays high for the next one
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic lst);
    int gap;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    s_axis_tlast  <= lst;
    expected_hsv.push_back(convert_pixel(r, g, b, lst));
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Receiver readiness: random stalls, or a long hold when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker
  initial begin
    hsv_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_hsv.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_hsv.pop_front();
          if (m_axis_tdata[14:0] !== want.hue)
            report_mismatch("hue", m_axis_tdata[14:0], want.hue);
          if (m_axis_tdata[22:15] !== want.sat)
            report_mismatch("saturation", m_axis_tdata[22:15], want.sat);
          if (m_axis_tdata[30:23] !== want.val)
            report_mismatch("value", m_axis_tdata[30:23], want.val);
          if (m_axis_tdata[31] !== 1'b0) report_mismatch("pad", m_axis_tdata[31], 0);
          if (m_axis_tlast !== want.last) report_mismatch("tlast", m_axis_tlast, want.last);
        end
      end
    end
  end

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);         // black
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);   // white, grey pixel
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd1, 1'b0);       // red sector wrap
    send_pixel(8'd255, 8'd0, 8'd254, 1'b0);
    send_pixel(8'd200, 8'd200, 8'd10, 1'b0);    // red/green tie goes green
    send_pixel(8'd10, 8'd200, 8'd200, 1'b0);    // green/blue tie
    send_pixel(8'd200, 8'd10, 8'd200, 1'b0);    // red/blue tie
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd1, 1'b1);
    send_pixel(8'd254, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd254, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd0, 1'b0);
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_pixel(8'($urandom), 8'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      else
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 9) == 0));
    end
  endtask

  // Receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    hold_cycles = 60;
    test_random(40);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_hsv.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    err_count = 0;
    hold_cycles = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(500);
    test_backpressure();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random(150);
    wait_drain();
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/rgbhsv_pkg.sv
src/rgbhsv_front.sv
src/rgbhsv_queue.sv
src/rgbhsv_back.sv
src/rgb_to_hsv_pixel.sv
tb/tb_rgb_to_hsv_pixel.sv
